// ===== rtl/jsu_pkg.sv =====
// Shared types, character codes and result-group helpers for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    localparam int unsigned GRP_MAX = 4;
    localparam int unsigned CNT_W   = $clog2(GRP_MAX + 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // top six bits of a code unit that mark high and low surrogates
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NO_QUOTE   = 3'd0,
        ERR_UNTERM     = 3'd1,
        ERR_ESC_CUT    = 3'd2,
        ERR_BAD_ESC    = 3'd3,
        ERR_BAD_HEX    = 3'd4,
        ERR_PAIR_INCMP = 3'd5,
        ERR_PAIR_BAD   = 3'd6
    } err_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        kind_t                    kind;
        err_t                     err;
        logic [GRP_MAX-1:0][7:0]  bytes;
    } grp_t;

    function automatic grp_t err_group(input err_t e);
        grp_t g;
        g       = '0;
        g.cnt   = CNT_W'(1);
        g.kind  = KIND_ERR;
        g.err   = e;
        return g;
    endfunction

    function automatic grp_t close_group();
        grp_t g;
        g      = '0;
        g.cnt  = CNT_W'(1);
        g.kind = KIND_CLOSE;
        return g;
    endfunction

    function automatic grp_t byte_group(input logic [7:0] b);
        grp_t g;
        g          = '0;
        g.cnt      = CNT_W'(1);
        g.kind     = KIND_BYTE;
        g.bytes[0] = b;
        return g;
    endfunction

    function automatic grp_t utf8_group(input logic [20:0] cp);
        grp_t g;
        g      = '0;
        g.kind = KIND_BYTE;
        if (cp <= 21'h7F) begin
            g.cnt      = CNT_W'(1);
            g.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            g.cnt      = CNT_W'(2);
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            g.cnt      = CNT_W'(3);
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            g.cnt      = CNT_W'(4);
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b0, 4'(c - 8'h37)};
        else
            v = 5'h10;
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// Decode state machine: turns one registered input byte into a group of results.
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] cur_byte,
    input  wire logic       cur_eot,
    output grp_t            grp
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_BODY,
        M_ESC,
        M_HEX0,
        M_HEX1,
        M_HEX2,
        M_HEX3,
        M_PBS,
        M_PU,
        M_LOW0,
        M_LOW1,
        M_LOW2,
        M_LOW3
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;

    logic [4:0]  hexd;
    logic [15:0] acc_shift;
    logic        bad_hex;

    assign hexd      = hex_value(cur_byte);
    assign bad_hex   = cur_eot || hexd[4];
    assign acc_shift = {acc_reg[11:0], hexd[3:0]};

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        hs_next   = hs_reg;
        grp       = '0;
        unique case (mode_reg)
            M_BODY:
            begin
                if (cur_eot)
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_UNTERM);
                end
                else if (cur_byte == CH_QUOTE)
                begin
                    mode_next = M_IDLE;
                    grp       = close_group();
                end
                else if (cur_byte == CH_BSL)
                    mode_next = M_ESC;
                else
                    grp = byte_group(cur_byte);
            end
            M_ESC:
            begin
                if (cur_eot)
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_ESC_CUT);
                end
                else
                begin
                    mode_next = M_BODY;
                    unique case (cur_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: grp = byte_group(cur_byte);
                        CH_B: grp = byte_group(CTL_BS);
                        CH_F: grp = byte_group(CTL_FF);
                        CH_N: grp = byte_group(CTL_LF);
                        CH_R: grp = byte_group(CTL_CR);
                        CH_T: grp = byte_group(CTL_TAB);
                        CH_U:
                        begin
                            acc_next  = '0;
                            mode_next = M_HEX0;
                        end
                        default:
                        begin
                            mode_next = M_IDLE;
                            acc_next  = '0;
                            hs_next   = '0;
                            grp       = err_group(ERR_BAD_ESC);
                        end
                    endcase
                end
            end
            M_HEX0, M_HEX1, M_HEX2, M_HEX3:
            begin
                if (bad_hex)
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_BAD_HEX);
                end
                else
                begin
                    acc_next = acc_shift;
                    if (mode_reg == M_HEX0)
                        mode_next = M_HEX1;
                    else if (mode_reg == M_HEX1)
                        mode_next = M_HEX2;
                    else if (mode_reg == M_HEX2)
                        mode_next = M_HEX3;
                    else if (acc_shift[15:10] == SURR_HI_TAG)
                    begin
                        hs_next   = acc_shift[9:0];
                        mode_next = M_PBS;
                    end
                    else
                    begin
                        mode_next = M_BODY;
                        grp       = utf8_group({5'b0, acc_shift});
                    end
                end
            end
            M_PBS:
            begin
                if (cur_eot || cur_byte != CH_BSL)
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_PAIR_INCMP);
                end
                else
                    mode_next = M_PU;
            end
            M_PU:
            begin
                if (cur_eot || cur_byte != CH_U)
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_PAIR_INCMP);
                end
                else
                begin
                    acc_next  = '0;
                    mode_next = M_LOW0;
                end
            end
            M_LOW0, M_LOW1, M_LOW2, M_LOW3:
            begin
                if (bad_hex || (mode_reg == M_LOW3 && acc_shift[15:10] != SURR_LO_TAG))
                begin
                    mode_next = M_IDLE;
                    acc_next  = '0;
                    hs_next   = '0;
                    grp       = err_group(ERR_PAIR_BAD);
                end
                else
                begin
                    acc_next = acc_shift;
                    if (mode_reg == M_LOW0)
                        mode_next = M_LOW1;
                    else if (mode_reg == M_LOW1)
                        mode_next = M_LOW2;
                    else if (mode_reg == M_LOW2)
                        mode_next = M_LOW3;
                    else
                    begin
                        mode_next = M_BODY;
                        grp       = utf8_group(SUPP_BASE + {1'b0, hs_reg, acc_shift[9:0]});
                    end
                end
            end
            default:
            begin
                // waiting for the opening quote
                mode_next = M_IDLE;
                if (!cur_eot)
                begin
                    if (cur_byte == CH_QUOTE)
                        mode_next = M_BODY;
                    else
                    begin
                        acc_next = '0;
                        hs_next  = '0;
                        grp      = err_group(ERR_NO_QUOTE);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
            hs_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            hs_reg   <= hs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsu_res_queue.sv =====
// Result-group queue and serializer: stores groups and hands out one result per transfer.
`default_nettype none

module jsu_res_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire grp_t       push_grp,
    output logic            can_push,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last_of_run
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(GRP_MAX);

    grp_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [IDX_W-1:0]  idx_reg;

    grp_t  head;
    logic  xfer;
    logic  pop;

    assign head        = mem_reg[rd_ptr_reg];
    assign can_push    = (occ_reg != OCC_W'(DEPTH));
    assign out_valid   = (occ_reg != '0);
    assign out_byte    = head.bytes[idx_reg];
    assign kind        = head.kind;
    assign error_code  = head.err;
    assign last_of_run = ({1'b0, idx_reg} == CNT_W'(head.cnt - CNT_W'(1)));
    assign xfer        = out_valid && out_ready;
    assign pop         = xfer && last_of_run;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                occ_reg <= occ_reg + OCC_W'(1);
            else if (pop && !push)
                occ_reg <= occ_reg - OCC_W'(1);
            if (pop)
                idx_reg <= '0;
            else if (xfer)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
`default_nettype none

// Takes a JSON string literal one byte per transfer, from its opening quote, and
// returns the decoded content as UTF-8 bytes, a close result on the closing quote,
// or one error result, after which it waits for a new opening quote. An input byte
// is registered, decoded combinationally by the mode state machine into a group of
// zero to four results, and the group is queued; results leave one per cycle while
// out_ready is high, the last one of a group flagged by last_of_run. A new byte is
// taken every cycle while the result queue (QUEUE_DEPTH groups) has room; it is held
// in the input register, then its group in the queue. Output bytes over a string never
// outnumber input bytes, so an always-ready sink lets input sustain one byte per cycle.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 5
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last_of_run
);

    logic       cur_valid_reg, cur_valid_next;
    logic [7:0] cur_byte_reg;
    logic       cur_eot_reg;
    logic       can_push;
    logic       fire;
    logic       in_xfer;
    grp_t       grp;

    assign fire     = cur_valid_reg && can_push;
    assign in_ready = !cur_valid_reg || can_push;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        if (in_xfer)
            cur_valid_next = 1'b1;
        else if (fire)
            cur_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else
            cur_valid_reg <= cur_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cur_byte_reg <= in_byte;
            cur_eot_reg  <= end_of_text;
        end
    end

    jsu_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cur_byte (cur_byte_reg),
        .cur_eot  (cur_eot_reg),
        .grp      (grp)
    );

    jsu_res_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (fire && (grp.cnt != '0)),
        .push_grp    (grp),
        .can_push    (can_push),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/jsu_checker.sv =====
// Port-level checks for the JSON string unescaper, bound to its top level.
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] in_byte,
    input wire logic       end_of_text,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] kind,
    input wire logic [2:0] error_code,
    input wire logic       last_of_run
);

    // an offered input sees a defined ready and carries a defined payload
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown({in_ready, in_byte, end_of_text}))
        else $error("unknown value on an offered input transfer");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // close and error results always stand alone
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> last_of_run)
        else $error("close or error result not last of its run");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> out_byte == 8'h00)
        else $error("non-byte result carries a byte");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERR |-> error_code == 3'd0)
        else $error("error code set on a non-error result");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

// ===== sim/json_string_unescape_utf8_tb.sv =====
// Testbench for json_string_unescape_utf8: directed and random JSON strings checked against a decoder model.
`timescale 1ns / 100ps

module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    // error_code reads 0 outside error results
    localparam err_t ERR_NONE = ERR_NO_QUOTE;
    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N,
                                               CH_R, CH_T};

    typedef enum logic [2:0] {
        DM_WAIT,
        DM_BODY,
        DM_ESC,
        DM_HEX,
        DM_PAIR_BSL,
        DM_PAIR_U,
        DM_LOW
    } dmode_t;

    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        err_t       err;
        logic       last;
    } decoded_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last_of_run;

    // decoder state mirrored by the predictor
    dmode_t      dec_mode = DM_WAIT;
    logic [15:0] unit_acc = '0;
    logic [9:0]  hi_bits  = '0;
    int          nib_idx  = 0;

    decoded_t    pending_out[$];
    decoded_t    head;
    logic [8:0]  text_buf[$];   // bit 8 marks end of text

    int idle_pct        = 0;
    int stall_pct       = 0;
    int hold_left       = 0;
    int mismatch_cnt    = 0;
    int results_checked = 0;
    int transfers_in    = 0;
    int cycle_cnt       = 0;

    json_string_unescape_utf8 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void add_result(input logic [7:0] b, input kind_t k, input err_t e);
        decoded_t r;
        r.data = b;
        r.kind = k;
        r.err  = e;
        r.last = 1'b0;
        pending_out = {pending_out, r};
    endfunction

    function automatic void decode_error(input err_t e);
        dec_mode = DM_WAIT;
        unit_acc = '0;
        hi_bits  = '0;
        add_result(8'h00, KIND_ERR, e);
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
            add_result(cp[7:0], KIND_BYTE, ERR_NONE);
        else if (cp < 21'h800)
        begin
            add_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
        else if (cp < 21'h10000)
        begin
            add_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
        else
        begin
            add_result({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
    endfunction

    function automatic void predict_transfer(input logic [7:0] c, input logic eot);
        int         first;
        logic [4:0] d;
        logic [7:0] esc_val;
        logic       esc_ok;
        first   = pending_out.size();
        esc_val = c;
        esc_ok  = 1'b1;
        case (dec_mode)
            DM_BODY:
            begin
                if (eot)
                    decode_error(ERR_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    dec_mode = DM_WAIT;
                    add_result(8'h00, KIND_CLOSE, ERR_NONE);
                end
                else if (c == CH_BSL)
                    dec_mode = DM_ESC;
                else
                    add_result(c, KIND_BYTE, ERR_NONE);
            end
            DM_ESC:
            begin
                if (eot)
                    decode_error(ERR_ESC_CUT);
                else
                begin
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: esc_val = c;
                        CH_B: esc_val = CTL_BS;
                        CH_F: esc_val = CTL_FF;
                        CH_N: esc_val = CTL_LF;
                        CH_R: esc_val = CTL_CR;
                        CH_T: esc_val = CTL_TAB;
                        CH_U:
                        begin
                            unit_acc = '0;
                            nib_idx  = 0;
                            dec_mode = DM_HEX;
                            esc_ok   = 1'b0;
                        end
                        default:
                        begin
                            decode_error(ERR_BAD_ESC);
                            esc_ok = 1'b0;
                        end
                    endcase
                    if (esc_ok)
                    begin
                        dec_mode = DM_BODY;
                        add_result(esc_val, KIND_BYTE, ERR_NONE);
                    end
                end
            end
            DM_HEX, DM_LOW:
            begin
                d = nibble_of(c);
                if (eot || d[4])
                    decode_error(dec_mode == DM_HEX ? ERR_BAD_HEX : ERR_PAIR_BAD);
                else
                begin
                    unit_acc = {unit_acc[11:0], d[3:0]};
                    if (nib_idx < 3)
                        nib_idx++;
                    else if (dec_mode == DM_HEX)
                    begin
                        if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF)
                        begin
                            hi_bits  = unit_acc[9:0];
                            dec_mode = DM_PAIR_BSL;
                        end
                        else
                        begin
                            dec_mode = DM_BODY;
                            emit_utf8({5'b0, unit_acc});
                        end
                    end
                    else if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF)
                        decode_error(ERR_PAIR_BAD);
                    else
                    begin
                        dec_mode = DM_BODY;
                        emit_utf8(21'h10000 + {1'b0, hi_bits, 10'b0} + {11'b0, unit_acc[9:0]});
                    end
                end
            end
            DM_PAIR_BSL:
            begin
                if (eot || c != CH_BSL)
                    decode_error(ERR_PAIR_INCMP);
                else
                    dec_mode = DM_PAIR_U;
            end
            DM_PAIR_U:
            begin
                if (eot || c != CH_U)
                    decode_error(ERR_PAIR_INCMP);
                else
                begin
                    unit_acc = '0;
                    nib_idx  = 0;
                    dec_mode = DM_LOW;
                end
            end
            default:
            begin
                // waiting for an opening quote; end of text is ignored here
                if (!eot)
                begin
                    if (c == CH_QUOTE)
                        dec_mode = DM_BODY;
                    else
                        decode_error(ERR_NO_QUOTE);
                end
            end
        endcase
        if (pending_out.size() > first)
            pending_out[pending_out.size() - 1].last = 1'b1;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected result byte=%02h kind=%0d code=%0d last=%0b",
                         $time, out_byte, kind, error_code, last_of_run);
                mismatch_cnt++;
            end
            else
            begin
                head = pending_out.pop_front();
                results_checked++;
                if (out_byte !== head.data)
                begin
                    $display("%0t: out_byte expected %02h, got %02h", $time, head.data, out_byte);
                    mismatch_cnt++;
                end
                if (kind !== head.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, head.kind, kind);
                    mismatch_cnt++;
                end
                if (error_code !== head.err)
                begin
                    $display("%0t: error_code expected %0d, got %0d", $time, head.err,
                             error_code);
                    mismatch_cnt++;
                end
                if (last_of_run !== head.last)
                begin
                    $display("%0t: last_of_run expected %0b, got %0b", $time, head.last,
                             last_of_run);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_out.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_item(input logic [7:0] b, input logic eot);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        transfers_in++;
        predict_transfer(b, eot);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + 8'(n);
        return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    function automatic void text_add(input logic [8:0] v);
        text_buf = {text_buf, v};
    endfunction

    function automatic void push_code_unit(input logic [15:0] cu);
        text_add({1'b0, CH_BSL});
        text_add({1'b0, CH_U});
        for (int i = 3; i >= 0; i--)
            text_add({1'b0, hex_char(cu[i*4 +: 4])});
    endfunction

    // one string with random content; most close cleanly, some are cut or corrupted
    task automatic send_random_string(input int max_elems, inout int sent);
        int          n_el;
        int          k;
        int          ending;
        logic [7:0]  b;
        logic [15:0] cu;
        logic [15:0] lo;
        text_buf.delete();
        if ($urandom_range(99) < 12)
        begin
            if ($urandom_range(1))
            begin
                send_item(8'($urandom), 1'b0);
                sent++;
            end
            else
                send_item(8'h00, 1'b1);
        end
        text_add({1'b0, CH_QUOTE});
        n_el = $urandom_range(max_elems);
        repeat (n_el)
        begin
            case ($urandom_range(9))
                4: text_add({1'b0, CH_BSL});
                5: push_code_unit(16'($urandom_range(16'h7F)));
                6: push_code_unit(16'($urandom_range(16'h7FF, 16'h80)));
                7:
                begin
                    cu = 16'($urandom_range(16'hFFFF, 16'h800));
                    if (cu >= 16'hD800 && cu <= 16'hDBFF)
                        cu = cu ^ 16'h2000;
                    push_code_unit(cu);
                end
                8: push_code_unit(16'($urandom_range(16'hDFFF, 16'hDC00)));
                9:
                begin
                    lo = 16'($urandom_range(16'hDFFF, 16'hDC00));
                    if ($urandom_range(7) == 0)
                        lo = 16'($urandom);
                    push_code_unit(16'($urandom_range(16'hDBFF, 16'hD800)));
                    push_code_unit(lo);
                end
                default:
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_QUOTE || b == CH_BSL);
                    text_add({1'b0, b});
                end
            endcase
            // a bare backslash above starts a simple escape
            if (text_buf[$] == {1'b0, CH_BSL} && text_buf.size() > 0
                && (text_buf.size() < 2 || text_buf[text_buf.size() - 2] != {1'b0, CH_U}))
                text_add({1'b0, ESC_LETTERS[$urandom_range(7)]});
        end
        ending = $urandom_range(99);
        if (ending < 78)
            text_add({1'b0, CH_QUOTE});
        else if (ending < 84)
            text_add({1'b1, 8'h00});
        else if (ending < 92)
        begin
            if (text_buf.size() > 1)
            begin
                k = $urandom_range(text_buf.size() - 1, 1);
                text_buf[k] = {1'b0, 8'($urandom)};
            end
            text_add({1'b0, CH_QUOTE});
        end
        else
        begin
            // cut the text short, often in the middle of an escape
            if (text_buf.size() > 1)
            begin
                k = $urandom_range(text_buf.size() - 1, 1);
                while (text_buf.size() > k)
                    void'(text_buf.pop_back());
            end
            text_add({1'b1, 8'($urandom)});
        end
        foreach (text_buf[i])
        begin
            send_item(text_buf[i][7:0], text_buf[i][8]);
            sent++;
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_framing();
        send_item(8'hFF, 1'b0);       // stray byte before any quote
        send_item(8'h00, 1'b1);       // end of text while waiting: nothing
        send_text("\"");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("\"");
    endtask

    task automatic test_code_units();
        // the narrowest one-byte value, the widest two- and three-byte values, a lone
        // low surrogate and the highest surrogate pair
        send_text("\"\\u0000\\u07ff\\uFFFF\\uDC00\\uDBFF\\uDFFF\\t\"");
    endtask

    task automatic test_error_codes();
        send_text("\"");
        send_item(8'h00, 1'b1);
        send_text("\"\\");
        send_item(8'h00, 1'b1);
        send_text("\"\\x");
        send_text("\"\\u1G");
        send_text("\"\\uD800x");
        send_text("\"\\uD800\\uE000");
    endtask

    task automatic test_random_flow(input int n_items, input int idle, input int stall);
        int sent;
        sent      = 0;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent < n_items)
            send_random_string(6, sent);
        wait_all_results();
    endtask

    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        // plain bytes only, so every transfer adds a result and the block fills up
        send_text("\"");
        repeat (40)
            send_item(8'($urandom_range(8'h5B, 8'h23)), 1'b0);
        send_text("\"");
        wait_all_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        end_of_text = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        test_framing();
        test_code_units();
        test_error_codes();
        wait_all_results();
        test_random_flow(30, 0, 0);
        test_random_flow(30, 69, 0);
        test_random_flow(30, 0, 69);
        test_random_flow(30, 21, 21);
        test_output_hold();

        repeat (20)
            @(posedge clk);
        $display("Sent %0d input transfers and checked %0d results.", transfers_in,
                 results_checked);
        $display("Covered framing, escapes, surrogate pairs, every error code, gaps and stalls.");
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
